@@ hw/rtl/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

    localparam int HUE_W = 12;
    localparam int CH_W  = 9;

    // floor(x / 6) estimate: (x * 682) >> 12 is low by at most one for 12-bit x
    localparam int SECT_RECIP_W = 10;
    localparam logic [SECT_RECIP_W-1:0] SECT_RECIP = 10'd682;
    localparam int SECTORS = 6;

    typedef enum logic [2:0] {
        SECT_0 = 3'd0,
        SECT_1 = 3'd1,
        SECT_2 = 3'd2,
        SECT_3 = 3'd3,
        SECT_4 = 3'd4,
        SECT_5 = 3'd5
    } t_sector;

    // x mod 6 by reciprocal multiply and a single correction step
    function automatic t_sector sector_of(input logic [HUE_W-1:0] x);
        logic [HUE_W+SECT_RECIP_W-1:0] prod;
        logic [SECT_RECIP_W-1:0]       quo;
        logic [HUE_W:0]                six_q;
        logic [HUE_W:0]                rem;
        prod  = (HUE_W+SECT_RECIP_W)'(x) * (HUE_W+SECT_RECIP_W)'(SECT_RECIP);
        quo   = prod[HUE_W+SECT_RECIP_W-1:HUE_W];
        six_q = (HUE_W+1)'(quo) * (HUE_W+1)'(SECTORS);
        rem   = (HUE_W+1)'(x) - six_q;
        if (rem >= (HUE_W+1)'(SECTORS)) begin
            rem = rem - (HUE_W+1)'(SECTORS);
        end
        return t_sector'(rem[2:0]);
    endfunction

endpackage

@@ hw/rtl/hsv2rgb_prep.sv @@
module hsv2rgb_prep #(
    parameter int CHANNEL_FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]        i_hue,
    input  logic [hsv2rgb_pkg::CH_W-1:0]         i_saturation,
    input  logic [hsv2rgb_pkg::CH_W-1:0]         i_value,
    output logic                                 o_valid,
    output hsv2rgb_pkg::t_sector                 o_sector,
    output logic [CHANNEL_FRAC_BITS-1:0]         o_frac,
    output logic [CHANNEL_FRAC_BITS:0]           o_sat,
    output logic [CHANNEL_FRAC_BITS:0]           o_val
);
    import hsv2rgb_pkg::*;

    localparam int F   = CHANNEL_FRAC_BITS;
    localparam int VW  = F + 1;
    localparam int IW  = (F + 1 > CH_W) ? F + 1 : CH_W;
    localparam int HXW = HUE_W + F;
    localparam logic [IW-1:0] ONE_I = IW'(1) << F;

    logic [HXW-1:0]   hue_x;
    logic [HUE_W-1:0] hue_sect;
    logic [IW-1:0]    sat_x;
    logic [IW-1:0]    val_x;
    logic [IW-1:0]    sat_c;
    logic [IW-1:0]    val_c;

    logic             r_valid;
    t_sector          r_sector;
    logic [F-1:0]     r_frac;
    logic [VW-1:0]    r_sat;
    logic [VW-1:0]    r_val;

    always_comb begin
        hue_x    = HXW'(i_hue);
        hue_sect = i_hue >> F;
        sat_x    = IW'(i_saturation);
        val_x    = IW'(i_value);
        sat_c    = (sat_x > ONE_I) ? ONE_I : sat_x;
        val_c    = (val_x > ONE_I) ? ONE_I : val_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sector <= sector_of(hue_sect);
            r_frac   <= hue_x[F-1:0];
            r_sat    <= sat_c[VW-1:0];
            r_val    <= val_c[VW-1:0];
        end
    end

    assign o_valid  = r_valid;
    assign o_sector = r_sector;
    assign o_frac   = r_frac;
    assign o_sat    = r_sat;
    assign o_val    = r_val;

endmodule

@@ hw/rtl/hsv2rgb_terms.sv @@
module hsv2rgb_terms #(
    parameter int CHANNEL_FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  hsv2rgb_pkg::t_sector                 i_sector,
    input  logic [CHANNEL_FRAC_BITS-1:0]         i_frac,
    input  logic [CHANNEL_FRAC_BITS:0]           i_sat,
    input  logic [CHANNEL_FRAC_BITS:0]           i_val,
    output logic                                 o_valid,
    output hsv2rgb_pkg::t_sector                 o_sector,
    output logic [CHANNEL_FRAC_BITS:0]           o_val,
    output logic [CHANNEL_FRAC_BITS:0]           o_p,
    output logic [CHANNEL_FRAC_BITS:0]           o_q,
    output logic [CHANNEL_FRAC_BITS:0]           o_t
);
    import hsv2rgb_pkg::*;

    localparam int F  = CHANNEL_FRAC_BITS;
    localparam int VW = F + 1;
    localparam int PW = 2 * F + 1;
    localparam logic [VW-1:0] ONE = VW'(1) << F;

    // first multiply stage: scaled saturation terms
    logic [VW-1:0] one_m_f;
    logic [PW-1:0] fs_prod;
    logic [PW-1:0] gs_prod;

    logic          r1_valid;
    t_sector       r1_sector;
    logic [VW-1:0] r1_val;
    logic [VW-1:0] r1_ap;
    logic [VW-1:0] r1_aq;
    logic [VW-1:0] r1_at;

    // second multiply stage: scale by value
    logic [PW-1:0] p_prod;
    logic [PW-1:0] q_prod;
    logic [PW-1:0] t_prod;

    logic          r2_valid;
    t_sector       r2_sector;
    logic [VW-1:0] r2_val;
    logic [VW-1:0] r2_p;
    logic [VW-1:0] r2_q;
    logic [VW-1:0] r2_t;

    always_comb begin
        one_m_f = ONE - VW'(i_frac);
        fs_prod = PW'(i_frac) * PW'(i_sat);
        gs_prod = PW'(one_m_f) * PW'(i_sat);
        p_prod  = PW'(r1_val) * PW'(r1_ap);
        q_prod  = PW'(r1_val) * PW'(r1_aq);
        t_prod  = PW'(r1_val) * PW'(r1_at);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_sector <= i_sector;
            r1_val    <= i_val;
            r1_ap     <= ONE - i_sat;
            r1_aq     <= ONE - fs_prod[PW-1:F];
            r1_at     <= ONE - gs_prod[PW-1:F];
            r2_sector <= r1_sector;
            r2_val    <= r1_val;
            r2_p      <= p_prod[PW-1:F];
            r2_q      <= q_prod[PW-1:F];
            r2_t      <= t_prod[PW-1:F];
        end
    end

    assign o_valid  = r2_valid;
    assign o_sector = r2_sector;
    assign o_val    = r2_val;
    assign o_p      = r2_p;
    assign o_q      = r2_q;
    assign o_t      = r2_t;

endmodule

@@ hw/rtl/hsv2rgb_route.sv @@
module hsv2rgb_route #(
    parameter int CHANNEL_FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  hsv2rgb_pkg::t_sector                 i_sector,
    input  logic [CHANNEL_FRAC_BITS:0]           i_val,
    input  logic [CHANNEL_FRAC_BITS:0]           i_p,
    input  logic [CHANNEL_FRAC_BITS:0]           i_q,
    input  logic [CHANNEL_FRAC_BITS:0]           i_t,
    output logic                                 o_valid,
    output logic [hsv2rgb_pkg::CH_W-1:0]         o_red,
    output logic [hsv2rgb_pkg::CH_W-1:0]         o_green,
    output logic [hsv2rgb_pkg::CH_W-1:0]         o_blue
);
    import hsv2rgb_pkg::*;

    localparam int VW = CHANNEL_FRAC_BITS + 1;

    logic [VW-1:0]   sel_r;
    logic [VW-1:0]   sel_g;
    logic [VW-1:0]   sel_b;

    logic            r_valid;
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;

    always_comb begin
        case (i_sector)
            SECT_0: begin
                sel_r = i_val; sel_g = i_t;   sel_b = i_p;
            end
            SECT_1: begin
                sel_r = i_q;   sel_g = i_val; sel_b = i_p;
            end
            SECT_2: begin
                sel_r = i_p;   sel_g = i_val; sel_b = i_t;
            end
            SECT_3: begin
                sel_r = i_p;   sel_g = i_q;   sel_b = i_val;
            end
            SECT_4: begin
                sel_r = i_t;   sel_g = i_p;   sel_b = i_val;
            end
            default: begin
                sel_r = i_val; sel_g = i_p;   sel_b = i_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // outputs keep only the low channel-width bits
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_red   <= CH_W'(sel_r);
            r_green <= CH_W'(sel_g);
            r_blue  <= CH_W'(sel_b);
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

@@ hw/rtl/hsv_to_rgb_converter.sv @@
// throughput: one pixel per cycle unless the output stalls; four register stages (clamp
// and sector split, saturation multiply, value multiply, channel select) advance together;
// the whole pipe holds while a finished result is stalled at the output
// reset: synchronous, active low; clears the stage valid bits only
module hsv_to_rgb_converter #(
    parameter int CHANNEL_FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]        i_hue,
    input  logic [hsv2rgb_pkg::CH_W-1:0]         i_saturation,
    input  logic [hsv2rgb_pkg::CH_W-1:0]         i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [hsv2rgb_pkg::CH_W-1:0]         o_red,
    output logic [hsv2rgb_pkg::CH_W-1:0]         o_green,
    output logic [hsv2rgb_pkg::CH_W-1:0]         o_blue
);
    import hsv2rgb_pkg::*;

    localparam int F = CHANNEL_FRAC_BITS;

    logic          adv;

    logic          s1_valid;
    t_sector       s1_sector;
    logic [F-1:0]  s1_frac;
    logic [F:0]    s1_sat;
    logic [F:0]    s1_val;

    logic          s3_valid;
    t_sector       s3_sector;
    logic [F:0]    s3_val;
    logic [F:0]    s3_p;
    logic [F:0]    s3_q;
    logic [F:0]    s3_t;

    // pipe moves unless the output register holds a transaction that is stalled
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    hsv2rgb_prep #(
        .CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_valid      (i_valid),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_value      (i_value),
        .o_valid      (s1_valid),
        .o_sector     (s1_sector),
        .o_frac       (s1_frac),
        .o_sat        (s1_sat),
        .o_val        (s1_val)
    );

    hsv2rgb_terms #(
        .CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)
    ) u_terms (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (s1_valid),
        .i_sector (s1_sector),
        .i_frac   (s1_frac),
        .i_sat    (s1_sat),
        .i_val    (s1_val),
        .o_valid  (s3_valid),
        .o_sector (s3_sector),
        .o_val    (s3_val),
        .o_p      (s3_p),
        .o_q      (s3_q),
        .o_t      (s3_t)
    );

    hsv2rgb_route #(
        .CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)
    ) u_route (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (s3_valid),
        .i_sector (s3_sector),
        .i_val    (s3_val),
        .i_p      (s3_p),
        .i_q      (s3_q),
        .i_t      (s3_t),
        .o_valid  (o_valid),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

endmodule

@@ sim/tb.sv @@
module tb;

    import hsv2rgb_pkg::*;

    localparam int FRAC       = 8;
    localparam int CH_ONE     = 1 << FRAC;
    localparam int IDLE_PCT   = 22;
    localparam int HOLD_LEN   = 200;
    localparam int STUCK_MAX  = 2000;
    localparam int DRAIN_WAIT = 12;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic [HUE_W-1:0]  i_hue        = '0;
    logic [CH_W-1:0]   i_saturation = '0;
    logic [CH_W-1:0]   i_value      = '0;
    logic              i_stall      = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [CH_W-1:0]   o_red;
    logic [CH_W-1:0]   o_green;
    logic [CH_W-1:0]   o_blue;

    t_rgb pending_rgb[$];
    int   mismatches   = 0;
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    bit   rx_hold_req  = 1'b0;
    int   rx_hold_cnt  = 0;
    int   stuck_cycles = 0;

    hsv_to_rgb_converter #(
        .CHANNEL_FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_hue       (i_hue),
        .i_saturation(i_saturation),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // expected color of one pixel, saturation and value clamped to one
    function automatic t_rgb hsv_pixel_to_rgb(input logic [HUE_W-1:0] hue,
                                              input logic [CH_W-1:0] sat_in,
                                              input logic [CH_W-1:0] val_in);
        int unsigned s;
        int unsigned v;
        int unsigned f;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        t_sector     sect;
        t_rgb        px;
        s    = (sat_in > CH_ONE) ? CH_ONE : sat_in;
        v    = (val_in > CH_ONE) ? CH_ONE : val_in;
        sect = t_sector'((int'(hue) >> FRAC) % SECTORS);
        f    = hue & (CH_ONE - 1);
        p    = (v * (CH_ONE - s)) >> FRAC;
        q    = (v * (CH_ONE - ((f * s) >> FRAC))) >> FRAC;
        t    = (v * (CH_ONE - (((CH_ONE - f) * s) >> FRAC))) >> FRAC;
        case (sect)
            SECT_0: px = '{CH_W'(v), CH_W'(t), CH_W'(p)};
            SECT_1: px = '{CH_W'(q), CH_W'(v), CH_W'(p)};
            SECT_2: px = '{CH_W'(p), CH_W'(v), CH_W'(t)};
            SECT_3: px = '{CH_W'(p), CH_W'(q), CH_W'(v)};
            SECT_4: px = '{CH_W'(t), CH_W'(p), CH_W'(v)};
            default: px = '{CH_W'(v), CH_W'(p), CH_W'(q)};
        endcase
        return px;
    endfunction

    // mostly in range, sometimes anything the 9-bit port can carry
    function automatic logic [CH_W-1:0] rand_channel();
        if ($urandom_range(99) < 80) begin
            return CH_W'($urandom_range(CH_ONE));
        end
        return CH_W'($urandom_range((1 << CH_W) - 1));
    endfunction

    // valid stays high after acceptance; a pause in the next call or wait_drained lowers it
    task automatic send_pixel(input logic [HUE_W-1:0] hue,
                              input logic [CH_W-1:0] sat,
                              input logic [CH_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_value      <= val;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        pending_rgb.push_back(hsv_pixel_to_rgb(hue, sat, val));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_rgb.size() != 0);
    endtask

    task automatic test_corners();
        logic [HUE_W-1:0] hues[12];
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hues = '{12'd0, 12'd255, 12'd256, 12'd511, 12'd512, 12'd768,
                 12'd1024, 12'd1280, 12'd1535, 12'd1536, 12'd2048, 12'd4095};
        // every sector and the wrap past six sectors at full color
        foreach (hues[i]) begin
            send_pixel(hues[i], 9'd256, 9'd256);
        end
        send_pixel(12'd128, 9'd0, 9'd256);
        send_pixel(12'd700, 9'd256, 9'd0);
        send_pixel(12'd0, 9'd0, 9'd0);
        // saturation and value above one get clamped
        send_pixel(12'd300, 9'd257, 9'd511);
        send_pixel(12'd1100, 9'd511, 9'd257);
        send_pixel(12'd4095, 9'd511, 9'd511);
        send_pixel(12'd1, 9'd1, 9'd1);
        send_pixel(12'd3583, 9'd255, 9'd255);
        send_pixel(12'd2730, 9'd128, 9'd200);
        wait_drained();
    endtask

    task automatic test_random_stream(input int n);
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        repeat (n) begin
            send_pixel(HUE_W'($urandom_range((1 << HUE_W) - 1)), rand_channel(),
                       rand_channel());
        end
        wait_drained();
    endtask

    task automatic test_back_to_back(input int n);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (n) begin
            send_pixel(HUE_W'($urandom_range((1 << HUE_W) - 1)), rand_channel(),
                       rand_channel());
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps pushing, so the pipe backs up
    task automatic test_output_holdoff(input int n);
        tx_idle_pct = 0;
        rx_idle_pct = IDLE_PCT;
        rx_hold_req = 1'b1;
        repeat (n) begin
            send_pixel(HUE_W'($urandom_range((1 << HUE_W) - 1)), rand_channel(),
                       rand_channel());
        end
        wait_drained();
    endtask

    task automatic test_burst_pauses(input int bursts, input int n);
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        repeat (bursts) begin
            repeat (n) begin
                send_pixel(HUE_W'($urandom_range((1 << HUE_W) - 1)), rand_channel(),
                           rand_channel());
            end
            wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_cnt = HOLD_LEN;
            rx_hold_req = 1'b0;
        end
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            got = '{o_red, o_green, o_blue};
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
                         got.red, got.green, got.blue);
                mismatches++;
            end else begin
                want = pending_rgb.pop_front();
                if (got.red !== want.red) begin
                    $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                    mismatches++;
                end
                if (got.green !== want.green) begin
                    $display("%0t: green expected %0d actual %0d", $time, want.green,
                             got.green);
                    mismatches++;
                end
                if (got.blue !== want.blue) begin
                    $display("%0t: blue expected %0d actual %0d", $time, want.blue,
                             got.blue);
                    mismatches++;
                end
            end
        end
    end

    // no transaction on either side for too long means the block is hung
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_MAX) begin
            $display("%0t: timeout, %0d pixels outstanding", $time, pending_rgb.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_random_stream(1000);
        test_back_to_back(600);
        test_output_holdoff(60);
        test_burst_pauses(4, 50);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
